// ===== hw/rtl/icx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icx_pkg
// Shared widths, opcode and relation codes, and the structs that pass
// between the execute unit, the register file and the data memory.
// ----------------------------------------------------------------------------
package icx_pkg;

  localparam int CMD_W    = 4;
  localparam int REG_W    = 3;
  localparam int REL_W    = 3;
  localparam int TGT_W    = 10;
  localparam int MADDR_IN_W = 10;
  localparam int DATA_W   = 32;
  localparam int PC_W     = 11;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // opcodes
  localparam logic [CMD_W-1:0] CMD_STORE = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_JUMP  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_IF    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ELSE  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PRINT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_READ  = 4'd9;

  // relations
  localparam logic [REL_W-1:0] REL_EQ = 3'd0;
  localparam logic [REL_W-1:0] REL_LT = 3'd1;
  localparam logic [REL_W-1:0] REL_GT = 3'd2;
  localparam logic [REL_W-1:0] REL_LE = 3'd3;
  localparam logic [REL_W-1:0] REL_GE = 3'd4;

  // configuration register index
  localparam logic [PADDR_W-3:0] CSR_PROGRAM_LENGTH = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [REG_W-1:0]      reg_a;
    logic [REL_W-1:0]      rel_op;
    logic [TGT_W-1:0]      target;
    logic [MADDR_IN_W-1:0] mem_addr;
    logic [DATA_W-1:0]     value;
  } instr_t;

  typedef struct packed {
    logic                  reg_we;
    logic [REG_W-1:0]      reg_idx;
    logic [DATA_W-1:0]     reg_data;
    logic                  mem_we;
    logic [MADDR_IN_W-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_data;
  } wb_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic [DATA_W-1:0] print_value;
    logic              print_valid;
    logic              halted;
    logic              stack_fault;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/intercode_instruction_executor.sv =====
// an accepted request and its register file and data memory reads are registered;
//   the execute stage then loads its result into the output register once that is free
// throughput: one instruction per cycle unless the output side stalls; register file
//   and data memory reads are forwarded from the write of the instruction just ahead
// reset: clears pc, stack depth, program_length and register valid bits;
//   data memory and condition stack contents are left as they are
`default_nettype none
// ----------------------------------------------------------------------------
// intercode_instruction_executor
// Executes one intermediate-code instruction per input request: registers
// and data memory are read at acceptance, the execute stage computes and
// writes back, and the result goes to an output register.
// ----------------------------------------------------------------------------
module intercode_instruction_executor #(
  parameter int MEM_WORDS   = 1024,
  parameter int STACK_DEPTH = 16,
  parameter int NUM_REGS    = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // instruction channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [icx_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [icx_pkg::REG_W-1:0]         in_reg_a,
  input  wire logic [icx_pkg::REG_W-1:0]         in_reg_b,
  input  wire logic [icx_pkg::REG_W-1:0]         in_reg_c,
  input  wire logic [icx_pkg::REL_W-1:0]         in_rel_op,
  input  wire logic [icx_pkg::TGT_W-1:0]         in_target,
  input  wire logic [icx_pkg::MADDR_IN_W-1:0]    in_mem_addr,
  input  wire logic signed [icx_pkg::DATA_W-1:0] in_in_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [icx_pkg::PC_W-1:0]               out_next_pc,
  output logic signed [icx_pkg::DATA_W-1:0]      out_print_value,
  output logic                                   out_print_valid,
  output logic                                   out_halted,
  output logic                                   out_stack_fault,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [icx_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [icx_pkg::PDATA_W-1:0]       pwdata,
  output logic [icx_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);
  import icx_pkg::*;

  logic [PC_W-1:0] prog_len_r;
  logic            cfg_wr;

  logic   e_valid_r;
  instr_t e_instr_r;
  logic   e_fire;
  logic   accept;

  logic [REG_W-1:0]  rf_addr0;
  logic [REG_W-1:0]  rf_addr1;
  logic [DATA_W-1:0] op_x;
  logic [DATA_W-1:0] op_y;
  logic [DATA_W-1:0] ld_data;

  res_t res;
  res_t res_r;
  wb_t  wb;
  logic out_valid_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == CSR_PROGRAM_LENGTH) ? PDATA_W'(prog_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == CSR_PROGRAM_LENGTH)) begin
      prog_len_r <= pwdata[PC_W-1:0];
    end
  end

  // handshake: execute stage advances when the output register frees up
  assign e_fire   = e_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !e_valid_r || e_fire;
  assign accept   = in_valid && in_ready;

  // arithmetic reads b and c, everything else reads a and b
  always_comb begin
    unique case (in_cmd) inside
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        rf_addr0 = in_reg_b;
        rf_addr1 = in_reg_c;
      end
      default: begin
        rf_addr0 = in_reg_a;
        rf_addr1 = in_reg_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_ready) begin
      e_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_instr_r.cmd      <= in_cmd;
      e_instr_r.reg_a    <= in_reg_a;
      e_instr_r.rel_op   <= in_rel_op;
      e_instr_r.target   <= in_target;
      e_instr_r.mem_addr <= in_mem_addr;
      e_instr_r.value    <= in_in_value;
    end
  end

  icx_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .raddr0 (rf_addr0),
    .raddr1 (rf_addr1),
    .rdata0 (op_x),
    .rdata1 (op_y),
    .wb     (wb)
  );

  icx_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rd_en (accept),
    .raddr (in_mem_addr),
    .rdata (ld_data),
    .wb    (wb)
  );

  icx_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (e_fire),
    .instr    (e_instr_r),
    .op_x     (op_x),
    .op_y     (op_y),
    .ld_data  (ld_data),
    .prog_len (prog_len_r),
    .res      (res),
    .wb       (wb)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = res_r.next_pc;
  assign out_print_value = res_r.print_value;
  assign out_print_valid = res_r.print_valid;
  assign out_halted      = res_r.halted;
  assign out_stack_fault = res_r.stack_fault;

`ifndef NO_ASSERTIONS
  a_fire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    e_fire |=> out_valid_r)
    else $error("executed instruction lost its result");

  a_print_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.print_valid |-> !res_r.stack_fault)
    else $error("print result flagged a stack fault");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !e_fire |-> !wb.reg_we && !wb.mem_we)
    else $error("write-back without an executing instruction");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/icx_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icx_regfile
// Register file: two synchronous read ports, one write port, per-entry valid
// bits so unwritten registers read as zero, and same-edge write forwarding.
// ----------------------------------------------------------------------------
module icx_regfile #(
  parameter int NUM_REGS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [icx_pkg::REG_W-1:0]   raddr0,
  input  wire logic [icx_pkg::REG_W-1:0]   raddr1,
  output logic      [icx_pkg::DATA_W-1:0]  rdata0,
  output logic      [icx_pkg::DATA_W-1:0]  rdata1,
  input  wire icx_pkg::wb_t                wb
);
  import icx_pkg::*;

  localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // index modulo register count, by repeated subtraction on a 3-bit value
  function automatic logic [RIDX_W-1:0] reg_idx(input logic [REG_W-1:0] r);
    logic [5:0] v;
    v = 6'(r);
    for (int i = 0; i < 4; i++) begin
      if (v >= 6'(NUM_REGS)) begin
        v = v - 6'(NUM_REGS);
      end
    end
    return v[RIDX_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  logic [RIDX_W-1:0] widx;
  logic [RIDX_W-1:0] ridx0;
  logic [RIDX_W-1:0] ridx1;

  logic [DATA_W-1:0] q0_r;
  logic [DATA_W-1:0] q1_r;
  logic              vld0_r;
  logic              vld1_r;
  logic              hit0_r;
  logic              hit1_r;
  logic [DATA_W-1:0] fwd_r;

  assign widx  = reg_idx(wb.reg_idx);
  assign ridx0 = reg_idx(raddr0);
  assign ridx1 = reg_idx(raddr1);

  always_ff @(posedge clk) begin
    if (wb.reg_we) begin
      mem[widx] <= wb.reg_data;
    end
    if (rd_en) begin
      q0_r   <= mem[ridx0];
      q1_r   <= mem[ridx1];
      vld0_r <= vld_r[ridx0];
      vld1_r <= vld_r[ridx1];
      hit0_r <= wb.reg_we && (widx == ridx0);
      hit1_r <= wb.reg_we && (widx == ridx1);
      fwd_r  <= wb.reg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wb.reg_we) begin
      vld_r[widx] <= 1'b1;
    end
  end

  assign rdata0 = hit0_r ? fwd_r : (vld0_r ? q0_r : '0);
  assign rdata1 = hit1_r ? fwd_r : (vld1_r ? q1_r : '0);

`ifndef NO_ASSERTIONS
  // a write leaves its entry marked as written
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wb.reg_we |=> vld_r[$past(widx)])
    else $error("register write did not set valid bit");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/icx_dmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icx_dmem
// Word-addressed data memory: one synchronous read port, one write port,
// same-edge write forwarding. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module icx_dmem #(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rd_en,
  input  wire logic [icx_pkg::MADDR_IN_W-1:0]   raddr,
  output logic      [icx_pkg::DATA_W-1:0]       rdata,
  input  wire icx_pkg::wb_t                     wb
);
  import icx_pkg::*;

  localparam int MADDR_W = $clog2(MEM_WORDS);

  // address modulo memory size, restoring remainder over shifted multiples
  function automatic logic [MADDR_W-1:0] word_idx(input logic [MADDR_IN_W-1:0] a);
    logic [23:0] v;
    v = 24'(a);
    for (int k = 6; k >= 0; k--) begin
      if (v >= (24'(MEM_WORDS) << k)) begin
        v = v - (24'(MEM_WORDS) << k);
      end
    end
    return v[MADDR_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [MEM_WORDS];

  logic [MADDR_W-1:0] widx;
  logic [MADDR_W-1:0] ridx;
  logic [DATA_W-1:0]  q_r;
  logic               hit_r;
  logic [DATA_W-1:0]  fwd_r;

  assign widx = word_idx(wb.mem_addr);
  assign ridx = word_idx(raddr);

  always_ff @(posedge clk) begin
    if (wb.mem_we) begin
      mem[widx] <= wb.mem_data;
    end
    if (rd_en) begin
      q_r   <= mem[ridx];
      hit_r <= wb.mem_we && (widx == ridx);
      fwd_r <= wb.mem_data;
    end
  end

  assign rdata = hit_r ? fwd_r : q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/icx_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icx_exec
// Execute stage: ALU, relation compare, program counter, condition stack
// (shift register with depth count) and write-back requests.
// ----------------------------------------------------------------------------
module icx_exec #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire icx_pkg::instr_t             instr,
  input  wire logic [icx_pkg::DATA_W-1:0]  op_x,
  input  wire logic [icx_pkg::DATA_W-1:0]  op_y,
  input  wire logic [icx_pkg::DATA_W-1:0]  ld_data,
  input  wire logic [icx_pkg::PC_W-1:0]    prog_len,
  output icx_pkg::res_t                    res,
  output icx_pkg::wb_t                     wb
);
  import icx_pkg::*;

  localparam int DEP_W = $clog2(STACK_DEPTH + 1);

  function automatic logic rel_holds(input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b,
                                     input logic [REL_W-1:0]  rel);
    logic r;
    case (rel)
      REL_EQ:  r = ($signed(a) == $signed(b));
      REL_LT:  r = ($signed(a) <  $signed(b));
      REL_GT:  r = ($signed(a) >  $signed(b));
      REL_LE:  r = ($signed(a) <= $signed(b));
      REL_GE:  r = ($signed(a) >= $signed(b));
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  logic [PC_W-1:0]        pc_r;
  logic [PC_W-1:0]        pc_nxt;
  logic [DEP_W-1:0]       depth_r;
  logic [DEP_W-1:0]       depth_nxt;
  logic [STACK_DEPTH-1:0] stack_r;
  logic [STACK_DEPTH-1:0] stack_nxt;

  logic [PC_W-1:0]   tgt;
  logic [DATA_W-1:0] prod;
  logic              cond;
  logic              reg_we;
  logic              mem_we;
  logic              fault;
  logic              pvalid;

  assign tgt  = PC_W'(instr.target);
  assign prod = op_x * op_y;
  assign cond = rel_holds(op_x, op_y, instr.rel_op);

  always_comb begin
    pc_nxt    = pc_r + PC_W'(1);
    depth_nxt = depth_r;
    stack_nxt = stack_r;
    reg_we    = 1'b0;
    mem_we    = 1'b0;
    fault     = 1'b0;
    pvalid    = 1'b0;
    wb          = '0;
    wb.reg_idx  = instr.reg_a;
    wb.mem_addr = instr.mem_addr;
    wb.mem_data = op_x;

    if (pc_r >= prog_len) begin
      // halted: instruction ignored
      pc_nxt = pc_r;
    end else begin
      unique case (instr.cmd)
        CMD_STORE: mem_we = 1'b1;
        CMD_LOAD: begin
          reg_we      = 1'b1;
          wb.reg_data = ld_data;
        end
        CMD_ADD: begin
          reg_we      = 1'b1;
          wb.reg_data = op_x + op_y;
        end
        CMD_SUB: begin
          reg_we      = 1'b1;
          wb.reg_data = op_x - op_y;
        end
        CMD_MUL: begin
          reg_we      = 1'b1;
          wb.reg_data = prod;
        end
        CMD_JUMP: pc_nxt = tgt + PC_W'(1);
        CMD_IF: begin
          if (!cond) begin
            pc_nxt = tgt;
          end
          // full stack drops the push but keeps the branch
          if (depth_r >= DEP_W'(STACK_DEPTH)) begin
            fault = 1'b1;
          end else begin
            stack_nxt = {stack_r[STACK_DEPTH-2:0], cond};
            depth_nxt = depth_r + DEP_W'(1);
          end
        end
        CMD_ELSE: begin
          if (depth_r == '0) begin
            fault = 1'b1;
          end else begin
            if (stack_r[0]) begin
              pc_nxt = tgt + PC_W'(1);
            end
            stack_nxt = {1'b0, stack_r[STACK_DEPTH-1:1]};
            depth_nxt = depth_r - DEP_W'(1);
          end
        end
        CMD_PRINT: pvalid = 1'b1;
        CMD_READ: begin
          reg_we      = 1'b1;
          wb.reg_data = instr.value;
        end
        default: ;
      endcase
    end

    wb.reg_we = reg_we && fire;
    wb.mem_we = mem_we && fire;

    res.next_pc     = pc_nxt;
    res.print_value = pvalid ? op_x : '0;
    res.print_valid = pvalid;
    res.halted      = (pc_nxt >= prog_len);
    res.stack_fault = fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      depth_r <= '0;
    end else if (fire) begin
      pc_r    <= pc_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stack_r <= stack_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(STACK_DEPTH))
    else $error("condition stack depth out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pc_r) && $stable(depth_r))
    else $error("pc or stack depth moved without an instruction");
`endif

endmodule
`default_nettype wire

// ===== sim/exec_checker.sv =====
// ----------------------------------------------------------------------------
// exec_checker
// Watches the instruction, result and configuration ports of the executor.
// Keeps its own copy of the machine state, executes every accepted request
// on it and compares each result, field by field, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module exec_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [icx_pkg::CMD_W-1:0]       in_cmd,
  input  logic [icx_pkg::REG_W-1:0]       in_reg_a,
  input  logic [icx_pkg::REG_W-1:0]       in_reg_b,
  input  logic [icx_pkg::REG_W-1:0]       in_reg_c,
  input  logic [icx_pkg::REL_W-1:0]       in_rel_op,
  input  logic [icx_pkg::TGT_W-1:0]       in_target,
  input  logic [icx_pkg::MADDR_IN_W-1:0]  in_mem_addr,
  input  logic [icx_pkg::DATA_W-1:0]      in_in_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [icx_pkg::PC_W-1:0]        out_next_pc,
  input  logic [icx_pkg::DATA_W-1:0]      out_print_value,
  input  logic                            out_print_valid,
  input  logic                            out_halted,
  input  logic                            out_stack_fault,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [icx_pkg::PADDR_W-1:0]     paddr,
  input  logic [icx_pkg::PDATA_W-1:0]     pwdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending,
  output logic [icx_pkg::PC_W-1:0]        mach_pc,
  output logic                            mach_halted,
  output logic [1023:0]                   mem_known
);
  import icx_pkg::*;

  localparam int MEM_WORDS   = 1024;
  localparam int STACK_DEPTH = 16;
  localparam int NUM_REGS    = 8;
  localparam logic [PADDR_W-1:0] LEN_ADDR = {CSR_PROGRAM_LENGTH, 2'b00};

  logic [DATA_W-1:0] gpr [NUM_REGS];
  logic [DATA_W-1:0] dmem [MEM_WORDS];
  logic [1023:0]     written;
  bit                cond_bits [STACK_DEPTH];
  int                cond_depth;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   prog_len;
  res_t              predicted_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic push_cond(input logic flag);
    if (cond_depth >= STACK_DEPTH) return 1'b1;
    cond_bits[cond_depth] = flag;
    cond_depth++;
    return 1'b0;
  endfunction

  function automatic res_t execute_insn(
    input logic [CMD_W-1:0]      cmd,
    input logic [REG_W-1:0]      ra,
    input logic [REG_W-1:0]      rb,
    input logic [REG_W-1:0]      rc,
    input logic [REL_W-1:0]      rel,
    input logic [TGT_W-1:0]      tgt,
    input logic [MADDR_IN_W-1:0] addr,
    input logic [DATA_W-1:0]     value
  );
    res_t            r;
    logic [PC_W-1:0] nxt;
    logic            holds;
    r = '0;
    // halted machine ignores the request and reports where it stopped
    if (pc >= prog_len) begin
      r.next_pc = pc;
      r.halted  = 1'b1;
      return r;
    end
    nxt = pc + PC_W'(1);
    case (cmd)
      CMD_STORE: begin
        dmem[addr]    = gpr[ra];
        written[addr] = 1'b1;
      end
      CMD_LOAD:  gpr[ra] = dmem[addr];
      CMD_ADD:   gpr[ra] = gpr[rb] + gpr[rc];
      CMD_SUB:   gpr[ra] = gpr[rb] - gpr[rc];
      CMD_MUL:   gpr[ra] = gpr[rb] * gpr[rc];
      CMD_JUMP:  nxt = PC_W'(tgt) + PC_W'(1);
      CMD_IF: begin
        case (rel)
          REL_EQ:  holds = $signed(gpr[ra]) == $signed(gpr[rb]);
          REL_LT:  holds = $signed(gpr[ra]) <  $signed(gpr[rb]);
          REL_GT:  holds = $signed(gpr[ra]) >  $signed(gpr[rb]);
          REL_LE:  holds = $signed(gpr[ra]) <= $signed(gpr[rb]);
          REL_GE:  holds = $signed(gpr[ra]) >= $signed(gpr[rb]);
          default: holds = 1'b0;
        endcase
        if (!holds) nxt = PC_W'(tgt);
        // branch still taken when the push overflows
        r.stack_fault = push_cond(holds);
      end
      CMD_ELSE: begin
        if (cond_depth == 0) begin
          r.stack_fault = 1'b1;
        end else begin
          if (cond_bits[cond_depth-1]) nxt = PC_W'(tgt) + PC_W'(1);
          cond_depth--;
        end
      end
      CMD_PRINT: begin
        r.print_value = gpr[ra];
        r.print_valid = 1'b1;
      end
      CMD_READ:  gpr[ra] = value;
      default: ;
    endcase
    pc        = nxt;
    r.next_pc = nxt;
    r.halted  = (nxt >= prog_len);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      errors     = 0;
      pc         = '0;
      prog_len   = '0;
      cond_depth = 0;
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
        prog_len = pwdata[PC_W-1:0];
      if (in_valid && in_ready)
        predicted_results.push_back(execute_insn(in_cmd, in_reg_a, in_reg_b, in_reg_c,
                                                 in_rel_op, in_target, in_mem_addr,
                                                 in_in_value));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request pending", 32'(out_next_pc), '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(out_next_pc), 32'(want.next_pc));
          if (out_print_value !== want.print_value)
            report_mismatch("print_value", out_print_value, want.print_value);
          if (out_print_valid !== want.print_valid)
            report_mismatch("print_valid", 32'(out_print_valid), 32'(want.print_valid));
          if (out_halted !== want.halted)
            report_mismatch("halted", 32'(out_halted), 32'(want.halted));
          if (out_stack_fault !== want.stack_fault)
            report_mismatch("stack_fault", 32'(out_stack_fault), 32'(want.stack_fault));
        end
      end
    end
    pending     <= predicted_results.size();
    mach_pc     <= pc;
    mach_halted <= (pc >= prog_len);
    mem_known   <= written;
  end

  initial written = '0;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed instruction streams into the intercode
// instruction executor under changing program lengths, with random idling
// on both channels, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
  import icx_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 1100;
  localparam int MAIN_ITEMS   = 1000;
  localparam int QUIET_FROM   = 950;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_RAND_LEN = 1022;
  localparam logic [PADDR_W-1:0] LEN_ADDR  = {CSR_PROGRAM_LENGTH, 2'b00};
  localparam logic [REL_W-1:0]   REL_NEVER = 3'd5;
  localparam logic [CMD_W-1:0]   CMD_NOP   = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [REG_W-1:0]      reg_a;
    logic [REG_W-1:0]      reg_b;
    logic [REG_W-1:0]      reg_c;
    logic [REL_W-1:0]      rel_op;
    logic [TGT_W-1:0]      target;
    logic [MADDR_IN_W-1:0] mem_addr;
    logic [DATA_W-1:0]     value;
  } insn_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [REG_W-1:0]      in_reg_a = '0;
  logic [REG_W-1:0]      in_reg_b = '0;
  logic [REG_W-1:0]      in_reg_c = '0;
  logic [REL_W-1:0]      in_rel_op = '0;
  logic [TGT_W-1:0]      in_target = '0;
  logic [MADDR_IN_W-1:0] in_mem_addr = '0;
  logic [DATA_W-1:0]     in_in_value = '0;
  logic                  out_ready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic [PC_W-1:0]       out_next_pc;
  logic [DATA_W-1:0]     out_print_value;
  logic                  out_print_valid;
  logic                  out_halted;
  logic                  out_stack_fault;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int                    errors;
  int                    pending;
  logic [PC_W-1:0]       mach_pc;
  logic                  mach_halted;
  logic [1023:0]         mem_known;

  logic                  hold_req = 1'b0;
  logic                  quiet = 1'b0;
  bit                    gaps_on;
  int                    executed;
  int                    sent;
  int                    ignored_streak;
  int                    cur_len;
  logic [MADDR_IN_W-1:0] stored_addrs [$];

  always #5 clk = ~clk;

  intercode_instruction_executor dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_reg_a, .in_reg_b, .in_reg_c, .in_rel_op,
    .in_target, .in_mem_addr, .in_in_value,
    .out_valid, .out_ready, .out_next_pc, .out_print_value, .out_print_valid,
    .out_halted, .out_stack_fault,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  exec_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_reg_a, .in_reg_b, .in_reg_c, .in_rel_op,
    .in_target, .in_mem_addr, .in_in_value,
    .out_valid, .out_ready, .out_next_pc, .out_print_value, .out_print_valid,
    .out_halted, .out_stack_fault,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .mach_pc, .mach_halted, .mem_known
  );

  // result side: short random stalls, calm stretches, one long hold-off
  int rx_hold_left;
  int rx_stall_left;
  bit rx_hold_done;
  bit rx_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (hold_req && !rx_hold_done) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (!quiet && !rx_calm && $urandom_range(0, 6) == 0) begin
        rx_stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic insn_t make_insn(
    input logic [CMD_W-1:0] cmd, input int ra, input int rb, input int rc,
    input logic [REL_W-1:0] rel, input int tgt, input int addr, input logic [31:0] val
  );
    insn_t t;
    t.cmd      = cmd;
    t.reg_a    = REG_W'(ra);
    t.reg_b    = REG_W'(rb);
    t.reg_c    = REG_W'(rc);
    t.rel_op   = rel;
    t.target   = TGT_W'(tgt);
    t.mem_addr = MADDR_IN_W'(addr);
    t.value    = val;
    return t;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_target();
    return $urandom_range(0, cur_len - 1);
  endfunction

  // loads only ever touch words the machine has really stored
  function automatic logic [MADDR_IN_W-1:0] pick_load_addr();
    logic [MADDR_IN_W-1:0] a;
    for (int i = 0; i < 8; i++) begin
      if (stored_addrs.size() == 0) break;
      a = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
      if (mem_known[a]) return a;
    end
    return '0;  // word 0 is stored during the directed part
  endfunction

  function automatic insn_t rand_insn();
    insn_t t;
    t = make_insn(CMD_W'($urandom_range(0, 15)), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 7), REL_W'($urandom_range(0, 7)), pick_target(),
                  $urandom_range(0, 1023), pick_value());
    if (t.cmd == CMD_LOAD) t.mem_addr = pick_load_addr();
    return t;
  endfunction

  function automatic insn_t rand_arith();
    logic [CMD_W-1:0] ops [5];
    ops = '{CMD_READ, CMD_ADD, CMD_SUB, CMD_MUL, CMD_PRINT};
    return make_insn(ops[$urandom_range(0, 4)], $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 7), REL_EQ, 0, 0, pick_value());
  endfunction

  task automatic send_insn(input insn_t t);
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= t.cmd;
    in_reg_a    <= t.reg_a;
    in_reg_b    <= t.reg_b;
    in_reg_c    <= t.reg_c;
    in_rel_op   <= t.rel_op;
    in_target   <= t.target;
    in_mem_addr <= t.mem_addr;
    in_in_value <= t.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (sent == HOLD_AT) hold_req <= 1'b1;
    if (sent == QUIET_FROM) quiet <= 1'b1;
    // state seen here is the one this request runs against
    if (mach_halted) begin
      ignored_streak++;
    end else begin
      ignored_streak = 0;
      executed++;
    end
    if (t.cmd == CMD_STORE) stored_addrs.push_back(t.mem_addr);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input int len);
    go_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= PDATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_len = len;
  endtask

  task automatic run_block();
    int n;
    int kind;
    int ra;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      n = $urandom_range(1, 4);
      repeat (n) send_insn(rand_arith());
    end else if (kind < 40) begin
      send_insn(make_insn(CMD_STORE, $urandom_range(0, 7), 0, 0, REL_EQ, 0,
                          $urandom_range(0, 1023), 0));
      send_insn(make_insn(CMD_LOAD, $urandom_range(0, 7), 0, 0, REL_EQ, 0,
                          pick_load_addr(), 0));
      if ($urandom_range(0, 1)) send_insn(make_insn(CMD_PRINT, $urandom_range(0, 7),
                                                    0, 0, REL_EQ, 0, 0, 0));
    end else if (kind < 60) begin
      // nested if / else with some work in between
      n = $urandom_range(1, 3);
      repeat (n) send_insn(make_insn(CMD_IF, $urandom_range(0, 7), $urandom_range(0, 7), 0,
                                     REL_W'($urandom_range(0, 7)), pick_target(), 0, 0));
      send_insn(rand_arith());
      repeat (n) send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, pick_target(), 0, 0));
    end else if (kind < 68 && cur_len - int'(mach_pc) > 50) begin
      // push to or past the stack top, then pop once more than was pushed
      n = $urandom_range(16, 19);
      repeat (n) begin
        ra = $urandom_range(0, 7);
        if ($urandom_range(0, 3) != 0)
          send_insn(make_insn(CMD_IF, ra, ra, 0, REL_EQ, pick_target(), 0, 0));
        else
          send_insn(make_insn(CMD_IF, ra, $urandom_range(0, 7), 0,
                              REL_W'($urandom_range(0, 7)), pick_target(), 0, 0));
      end
      repeat (n + 1) send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, pick_target(), 0, 0));
    end else if (kind < 76) begin
      send_insn(make_insn(CMD_JUMP, 0, 0, 0, REL_EQ, pick_target(), 0, 0));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_insn(rand_insn());
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    int budget;
    int len;
    executed = 0;
    sent = 0;
    ignored_streak = 0;
    gaps_on = 1'b1;
    cur_len = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length program: everything is ignored
    set_length(0);
    send_insn(make_insn(CMD_ADD, 1, 2, 3, REL_EQ, 0, 0, 0));
    // one instruction, then halted
    set_length(1);
    send_insn(make_insn(CMD_READ, 6, 0, 0, REL_EQ, 0, 0, 32'h1234_5678));
    send_insn(make_insn(CMD_PRINT, 6, 0, 0, REL_EQ, 0, 0, 0));

    set_length(1000);
    send_insn(make_insn(CMD_READ, 0, 0, 0, REL_EQ, 0, 0, 32'h7FFF_FFFF));
    send_insn(make_insn(CMD_READ, 1, 0, 0, REL_EQ, 0, 0, 32'h8000_0000));
    send_insn(make_insn(CMD_READ, 7, 0, 0, REL_EQ, 0, 0, 32'hFFFF_FFFF));
    send_insn(make_insn(CMD_STORE, 1, 0, 0, REL_EQ, 0, 1023, 0));
    send_insn(make_insn(CMD_STORE, 0, 0, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_LOAD, 2, 0, 0, REL_EQ, 0, 1023, 0));
    send_insn(make_insn(CMD_ADD, 3, 0, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_SUB, 4, 1, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_MUL, 5, 1, 7, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_PRINT, 5, 0, 0, REL_EQ, 0, 0, 0));
    // else on an empty stack
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 500, 0, 0));
    send_insn(make_insn(CMD_IF, 0, 1, 0, REL_GT, 900, 0, 0));
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 40, 0, 0));
    send_insn(make_insn(CMD_IF, 0, 1, 0, REL_LT, 20, 0, 0));
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 100, 0, 0));
    send_insn(make_insn(CMD_IF, 2, 1, 0, REL_EQ, 300, 0, 0));
    send_insn(make_insn(CMD_IF, 0, 1, 0, REL_LE, 60, 0, 0));
    send_insn(make_insn(CMD_IF, 7, 7, 0, REL_GE, 70, 0, 0));
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 10, 0, 0));
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 200, 0, 0));
    send_insn(make_insn(CMD_ELSE, 0, 0, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_JUMP, 0, 0, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_NOP, 0, 0, 0, REL_EQ, 0, 0, 0));
    send_insn(make_insn(CMD_PRINT, 4, 0, 0, REL_EQ, 0, 0, 0));

    // random phases, each under a fresh program length above the current pc
    while (sent < MAIN_ITEMS) begin
      go_idle();
      if (int'(mach_pc) >= MAX_RAND_LEN) break;
      case ($urandom_range(0, 3))
        0:       len = int'(mach_pc) + 1;
        1:       len = int'(mach_pc) + 2;
        2:       len = MAX_RAND_LEN;
        default: len = $urandom_range(int'(mach_pc) + 1, MAX_RAND_LEN);
      endcase
      if (len > MAX_RAND_LEN) len = MAX_RAND_LEN;
      set_length(len);
      budget = $urandom_range(40, 160);
      phase_start = executed;
      ignored_streak = 0;
      gaps_on = ($urandom_range(0, 3) != 0);
      while (executed - phase_start < budget && sent < MAIN_ITEMS && ignored_streak < 2)
        run_block();
    end

    // last stretch at full length, ending in a jump off the end
    set_length(1024);
    ignored_streak = 0;
    while (sent < TARGET_ITEMS) run_block();
    send_insn(make_insn(CMD_IF, 0, 0, 0, REL_NEVER, 1023, 0, 0));
    send_insn(make_insn(CMD_JUMP, 0, 0, 0, REL_EQ, 1023, 0, 0));
    send_insn(make_insn(CMD_READ, 3, 0, 0, REL_EQ, 0, 0, 32'hDEAD_BEEF));
    go_idle();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
